/* rtl/core/pidspd_pkg.sv */
package pidspd_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned TARGETS      = 4;

  localparam int unsigned CH_W       = 2;
  localparam int unsigned DELTA_W    = 12;
  localparam int unsigned SPEED_W    = 19;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned PROD_W     = 33;
  localparam int unsigned SUM_W      = 35;
  localparam int unsigned DRIVE_W    = 32;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned RECIP5_SHIFT = 14;
  localparam logic [DELTA_W-1:0]        RECIP5    = 12'd3277;
  localparam logic signed [SPEED_W-1:0] SPEED_INT = 19'sd82;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sd65534;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET0 = 3'd0,
    REG_TARGET1 = 3'd1,
    REG_TARGET2 = 3'd2,
    REG_TARGET3 = 3'd3,
    REG_GAIN_P  = 3'd4,
    REG_GAIN_I  = 3'd5,
    REG_GAIN_D  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } gains_t;

  typedef struct packed {
    logic                       vld;
    logic                       wr;
    logic [CH_W-1:0]            ch;
    logic signed [SPEED_W-1:0]  speed;
    logic signed [ERR_W-1:0]    target;
  } p1_t;

  typedef struct packed {
    logic                       vld;
    logic                       wr;
    logic [CH_W-1:0]            ch;
    logic signed [SPEED_W-1:0]  speed;
    logic signed [ERR_W-1:0]    err;
    logic signed [ERR_W-1:0]    deriv;
    logic signed [ERR_W-1:0]    esum;
  } p2_t;

endpackage

/* rtl/core/pidspd_in_if.sv */
interface pidspd_in_if;
  import pidspd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CH_W-1:0]           channel;
  logic signed [DELTA_W-1:0] encoder_delta;

  modport source (output valid, output channel, output encoder_delta, input ready);
  modport sink   (input valid, input channel, input encoder_delta, output ready);
endinterface

/* rtl/core/pidspd_out_if.sv */
interface pidspd_out_if;
  import pidspd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CH_W-1:0]           out_channel;
  logic signed [DRIVE_W-1:0] drive_value;
  logic signed [SPEED_W-1:0] measured_speed;

  modport source (output valid, output out_channel, output drive_value,
                  output measured_speed, input ready);
  modport sink   (input valid, input out_channel, input drive_value,
                  input measured_speed, output ready);
endinterface

/* rtl/core/four_channel_incremental_pid_speed_unit.sv */
// channel  dir  word
// in_i     in   channel, encoder_delta
// out_o    out  out_channel, drive_value, measured_speed
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One word per cycle unless out_o stalls; words move via p1, p2, p3, p4, out.
// Per-channel error state and drive accumulators live in two RAMs, one read
// and one write per cycle each, with forwarding between neighboring words.
// Reset clears all settings and state at once; no clearing pass.
// A stalled output word stalls the whole pipeline and drops in_i.ready.
module four_channel_incremental_pid_speed_unit #(
  parameter int unsigned CHANNELS = pidspd_pkg::CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  pidspd_in_if.sink                            in_i,
  pidspd_out_if.source                         out_o,
  input  logic                                 cfg_we_i,
  input  logic [pidspd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pidspd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pidspd_pkg::*;

  logic signed [ERR_W-1:0]   target_q [TARGETS];
  gains_t                    gains_q;
  logic                      adv;
  logic                      accept;
  logic                      out_vld;
  logic [DELTA_W-1:0]        mag;
  logic [2*DELTA_W-1:0]      recip_prod;
  logic signed [SPEED_W-1:0] fifth;
  logic signed [SPEED_W-1:0] base;
  logic signed [SPEED_W-1:0] speed;
  p1_t                       p1_d, p1_q;
  p2_t                       p2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TARGETS; i++) begin
        target_q[i] <= '0;
      end
      gains_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET0: target_q[0]   <= $signed(cfg_data_i);
        REG_TARGET1: target_q[1]   <= $signed(cfg_data_i);
        REG_TARGET2: target_q[2]   <= $signed(cfg_data_i);
        REG_TARGET3: target_q[3]   <= $signed(cfg_data_i);
        REG_GAIN_P:  gains_q.prop  <= cfg_data_i;
        REG_GAIN_I:  gains_q.integ <= cfg_data_i;
        REG_GAIN_D:  gains_q.deriv <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = !out_vld || out_o.ready;
  assign in_i.ready = adv;
  assign accept     = in_i.valid && adv;

  // speed = 82 * delta + trunc(delta / 5)
  always_comb begin
    mag        = in_i.encoder_delta[DELTA_W-1] ? (~$unsigned(in_i.encoder_delta) + DELTA_W'(1))
                                               : $unsigned(in_i.encoder_delta);
    recip_prod = mag * RECIP5;
    fifth      = $signed(SPEED_W'(recip_prod >> RECIP5_SHIFT));
    base       = SPEED_W'(in_i.encoder_delta) * SPEED_INT;
    speed      = in_i.encoder_delta[DELTA_W-1] ? (base - fifth) : (base + fifth);
    p1_d.vld    = accept;
    p1_d.wr     = accept && (int'(in_i.channel) < CHANNELS);
    p1_d.ch     = in_i.channel;
    p1_d.speed  = speed;
    p1_d.target = target_q[in_i.channel];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
    end else if (adv) begin
      p1_q <= p1_d;
    end
  end

  pidspd_err #(
    .CHANNELS (CHANNELS)
  ) u_err (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .rd_en_i (accept),
    .rd_ch_i (in_i.channel),
    .p1_i    (p1_q),
    .p2_o    (p2)
  );

  pidspd_drv #(
    .CHANNELS (CHANNELS)
  ) u_drv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .gains_i     (gains_q),
    .p2_i        (p2),
    .out_vld_o   (out_vld),
    .out_ch_o    (out_o.out_channel),
    .out_drive_o (out_o.drive_value),
    .out_speed_o (out_o.measured_speed)
  );

  assign out_o.valid = out_vld;

  a_drive_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.drive_value <= DRIVE_MAX))
    else $error("drive above upper clamp");

  a_unused_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (int'(out_o.out_channel) >= CHANNELS)) |-> (out_o.drive_value == '0))
    else $error("nonzero drive for unused channel");
endmodule

/* rtl/core/pidspd_ram.sv */
module pidspd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/core/pidspd_err.sv */
module pidspd_err #(
  parameter int unsigned CHANNELS = pidspd_pkg::CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          rd_en_i,
  input  logic [pidspd_pkg::CH_W-1:0]   rd_ch_i,
  input  pidspd_pkg::p1_t               p1_i,
  output pidspd_pkg::p2_t               p2_o
);
  import pidspd_pkg::*;

  localparam int unsigned IDX_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int unsigned MEM_W = 2 * ERR_W;

  logic [CHANNELS-1:0]      vld_q;
  logic                     rvld_q;
  logic [MEM_W-1:0]         rdata;
  logic [IDX_W-1:0]         raddr;
  logic [IDX_W-1:0]         waddr;
  logic                     we;
  logic signed [ERR_W-1:0]  last_err;
  logic signed [ERR_W-1:0]  esum_prev;
  p2_t                      p2_d;
  p2_t                      p2_q;

  assign raddr = IDX_W'(rd_ch_i);
  assign waddr = IDX_W'(p1_i.ch);
  assign we    = adv_i && p1_i.wr;

  pidspd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (CHANNELS)
  ) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({p2_d.err, p2_d.esum}),
    .re_i    (rd_en_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    if (p2_q.wr && (p2_q.ch == p1_i.ch)) begin
      last_err  = p2_q.err;
      esum_prev = p2_q.esum;
    end else if (rvld_q) begin
      last_err  = $signed(rdata[MEM_W-1:ERR_W]);
      esum_prev = $signed(rdata[ERR_W-1:0]);
    end else begin
      last_err  = '0;
      esum_prev = '0;
    end
    p2_d.vld   = p1_i.vld;
    p2_d.wr    = p1_i.wr;
    p2_d.ch    = p1_i.ch;
    p2_d.speed = p1_i.speed;
    p2_d.err   = p1_i.target - $signed(p1_i.speed[ERR_W-1:0]);
    p2_d.deriv = p2_d.err - last_err;
    p2_d.esum  = esum_prev + p2_d.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      p2_q   <= '0;
    end else begin
      if (rd_en_i) begin
        rvld_q <= vld_q[raddr];
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (adv_i) begin
        p2_q <= p2_d;
      end
    end
  end

  assign p2_o = p2_q;
endmodule

/* rtl/core/pidspd_drv.sv */
module pidspd_drv #(
  parameter int unsigned CHANNELS = pidspd_pkg::CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  pidspd_pkg::gains_t                 gains_i,
  input  pidspd_pkg::p2_t                    p2_i,
  output logic                               out_vld_o,
  output logic [pidspd_pkg::CH_W-1:0]        out_ch_o,
  output logic signed [pidspd_pkg::DRIVE_W-1:0] out_drive_o,
  output logic signed [pidspd_pkg::SPEED_W-1:0] out_speed_o
);
  import pidspd_pkg::*;

  localparam int unsigned IDX_W  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int unsigned WIDE_W = DRIVE_W + 2;

  typedef struct packed {
    logic                       vld;
    logic                       wr;
    logic [CH_W-1:0]            ch;
    logic signed [SPEED_W-1:0]  speed;
    logic signed [PROD_W-1:0]   prop;
    logic signed [PROD_W-1:0]   integ;
    logic signed [PROD_W-1:0]   deriv;
  } p3_t;

  typedef struct packed {
    logic                       vld;
    logic                       wr;
    logic [CH_W-1:0]            ch;
    logic signed [SPEED_W-1:0]  speed;
    logic signed [SUM_W-1:0]    total;
  } p4_t;

  p3_t                          p3_d, p3_q;
  p4_t                          p4_d, p4_q;
  logic                         acc_rvld_q;
  logic [CHANNELS-1:0]          acc_vld_q;
  logic [DRIVE_W-1:0]           acc_rdata;
  logic [IDX_W-1:0]             raddr;
  logic [IDX_W-1:0]             waddr;
  logic                         we;
  logic signed [DRIVE_W-1:0]    acc;
  logic signed [WIDE_W-1:0]     floor_sum;
  logic signed [WIDE_W-1:0]     drive_wide;
  logic signed [DRIVE_W-1:0]    drive_clamp;
  logic                         out_vld_q;
  logic                         out_wr_q;
  logic [CH_W-1:0]              out_ch_q;
  logic signed [DRIVE_W-1:0]    out_drive_q;
  logic signed [SPEED_W-1:0]    out_speed_q;

  always_comb begin
    p3_d.vld   = p2_i.vld;
    p3_d.wr    = p2_i.wr;
    p3_d.ch    = p2_i.ch;
    p3_d.speed = p2_i.speed;
    p3_d.prop  = $signed({1'b0, gains_i.prop}) * p2_i.err;
    p3_d.integ = $signed({1'b0, gains_i.integ}) * p2_i.esum;
    p3_d.deriv = $signed({1'b0, gains_i.deriv}) * p2_i.deriv;
  end

  always_comb begin
    p4_d.vld   = p3_q.vld;
    p4_d.wr    = p3_q.wr;
    p4_d.ch    = p3_q.ch;
    p4_d.speed = p3_q.speed;
    p4_d.total = SUM_W'(p3_q.prop) + SUM_W'(p3_q.integ) + SUM_W'(p3_q.deriv);
  end

  assign raddr = IDX_W'(p3_q.ch);
  assign waddr = IDX_W'(p4_q.ch);
  assign we    = adv_i && p4_q.wr;

  pidspd_ram #(
    .WIDTH (DRIVE_W),
    .DEPTH (CHANNELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (drive_clamp),
    .re_i    (adv_i),
    .raddr_i (raddr),
    .rdata_o (acc_rdata)
  );

  always_comb begin
    if (out_wr_q && (out_ch_q == p4_q.ch)) begin
      acc = out_drive_q;
    end else if (acc_rvld_q) begin
      acc = $signed(acc_rdata);
    end else begin
      acc = '0;
    end
    floor_sum  = WIDE_W'(acc) + WIDE_W'($signed(p4_q.total[SUM_W-1:FRAC_W]));
    drive_wide = floor_sum
               + WIDE_W'({1'b0, floor_sum[WIDE_W-1] && (p4_q.total[FRAC_W-1:0] != '0)});
    if (drive_wide > WIDE_W'(DRIVE_MAX)) begin
      drive_clamp = DRIVE_MAX;
    end else if (drive_wide < WIDE_W'(DRIVE_MIN)) begin
      drive_clamp = DRIVE_MIN;
    end else begin
      drive_clamp = drive_wide[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_q        <= '0;
      p4_q        <= '0;
      acc_rvld_q  <= 1'b0;
      acc_vld_q   <= '0;
      out_vld_q   <= 1'b0;
      out_wr_q    <= 1'b0;
      out_ch_q    <= '0;
      out_drive_q <= '0;
      out_speed_q <= '0;
    end else if (adv_i) begin
      p3_q        <= p3_d;
      p4_q        <= p4_d;
      acc_rvld_q  <= acc_vld_q[raddr];
      if (p4_q.wr) begin
        acc_vld_q[waddr] <= 1'b1;
      end
      out_vld_q   <= p4_q.vld;
      out_wr_q    <= p4_q.wr;
      out_ch_q    <= p4_q.ch;
      out_speed_q <= p4_q.speed;
      out_drive_q <= p4_q.wr ? drive_clamp : '0;
    end
  end

  assign out_vld_o   = out_vld_q;
  assign out_ch_o    = out_ch_q;
  assign out_drive_o = out_drive_q;
  assign out_speed_o = out_speed_q;
endmodule

/* tb/sv/tb_four_channel_incremental_pid_speed_unit.sv */
module tb_four_channel_incremental_pid_speed_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pidspd_pkg::*;

  localparam int NREGS      = 7;
  localparam int PIPE_DEPTH = 6;
  localparam int SPEED_NUM  = 822;
  localparam int SPEED_DEN  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_VOID = 3'd7;

  typedef logic [CFG_DATA_W-1:0] reg_set_t [NREGS];

  typedef struct packed {
    logic [CH_W-1:0]            ch;
    logic signed [DRIVE_W-1:0]  drive;
    logic signed [SPEED_W-1:0]  speed;
  } drive_word_t;

  typedef struct packed {
    logic                       is_reg;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      data;
    logic [CH_W-1:0]            ch;
    logic signed [DELTA_W-1:0]  delta;
    logic                       typed;
    logic signed [DRIVE_W-1:0]  drive;
    logic signed [SPEED_W-1:0]  speed;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pidspd_in_if  in_if();
  pidspd_out_if out_if();

  four_channel_incremental_pid_speed_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // controller copy: settings and per-channel loop state
  reg_set_t                  regs;
  logic signed [ERR_W-1:0]   last_err  [CHANNELS_DEF];
  logic signed [ERR_W-1:0]   err_sum   [CHANNELS_DEF];
  logic signed [DRIVE_W-1:0] drive_acc [CHANNELS_DEF];

  drive_word_t pending_drives [$];
  int          bad_fields = 0;
  bit          steady = 1'b0;

  step_row_t plan [32] = '{
    '{1'b0, REG_TARGET0, 16'h0000, 2'd0, -12'sd2048, 1'b1, 32'sd0, -19'sd168345},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd1,  12'sd2047, 1'b1, 32'sd0,  19'sd168263},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd2,  12'sd0,    1'b1, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd3, -12'sd1,    1'b1, 32'sd0, -19'sd82},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd3,  12'sd1,    1'b1, 32'sd0,  19'sd82},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd0, -12'sd5,    1'b1, 32'sd0, -19'sd411},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd1,  12'sd5,    1'b1, 32'sd0,  19'sd411},
    '{1'b1, REG_TARGET0, 16'h7FFF, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_TARGET1, 16'h8000, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_TARGET2, 16'd1000, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_TARGET3, 16'hFC18, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_GAIN_P,  16'h0100, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_GAIN_I,  16'h0080, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_GAIN_D,  16'h0040, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_VOID,    16'hFFFF, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd1,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd1,  12'sd2047, 1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd2,  12'sd12,   1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd3, -12'sd12,   1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd2, -12'sd2048, 1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd0, -12'sd2048, 1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_GAIN_P,  16'hFFFF, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_GAIN_I,  16'hFFFF, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_GAIN_D,  16'hFFFF, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b1, REG_TARGET2, 16'h7FFF, 2'd0,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd2,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd2,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd2,  12'sd0,    1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd3,  12'sd2047, 1'b0, 32'sd0,  19'sd0},
    '{1'b0, REG_TARGET0, 16'h0000, 2'd1, -12'sd2048, 1'b0, 32'sd0,  19'sd0}
  };

  function automatic drive_word_t pid_update(input logic [CH_W-1:0] ch,
                                             input logic signed [DELTA_W-1:0] delta);
    longint      spd;
    longint      tmp;
    longint      mix;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] deriv;
    drive_word_t w;
    spd = (longint'(delta) * SPEED_NUM) / SPEED_DEN;
    tmp = longint'(signed'(regs[ch])) - spd;
    err = tmp[ERR_W-1:0];
    tmp = longint'(err) - longint'(last_err[ch]);
    deriv = tmp[ERR_W-1:0];
    tmp = longint'(err_sum[ch]) + longint'(err);
    err_sum[ch] = tmp[ERR_W-1:0];
    mix = longint'(regs[REG_GAIN_P]) * longint'(err)
        + longint'(regs[REG_GAIN_D]) * longint'(deriv)
        + longint'(regs[REG_GAIN_I]) * longint'(err_sum[ch]);
    tmp = (longint'(drive_acc[ch]) * 256 + mix) / 256;
    if (tmp > longint'(DRIVE_MAX)) tmp = longint'(DRIVE_MAX);
    if (tmp < longint'(DRIVE_MIN)) tmp = longint'(DRIVE_MIN);
    drive_acc[ch] = tmp[DRIVE_W-1:0];
    last_err[ch] = err;
    w.ch = ch;
    w.drive = drive_acc[ch];
    w.speed = spd[SPEED_W-1:0];
    return w;
  endfunction

  function automatic logic signed [DELTA_W-1:0] random_delta();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return -12'sd2048;
      1: return 12'sd2047;
      2: return 12'sd0;
      3, 4, 5: return DELTA_W'(int'($urandom_range(0, 40)) - 20);
      default: return r[DELTA_W-1:0];
    endcase
  endfunction

  function automatic reg_set_t random_settings();
    reg_set_t s;
    logic [31:0] r;
    for (int i = 0; i < NREGS; i++) begin
      r = $urandom;
      case ($urandom_range(0, 7))
        0: s[i] = (i < TARGETS) ? 16'h8000 : 16'h0000;
        1: s[i] = (i < TARGETS) ? 16'h7FFF : 16'hFFFF;
        2, 3: s[i] = (i < TARGETS) ? CFG_DATA_W'(int'($urandom_range(0, 4000)) - 2000)
                                   : {6'h00, r[9:0]};
        default: s[i] = r[CFG_DATA_W-1:0];
      endcase
    end
    return s;
  endfunction

  task automatic note_error(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    bad_fields++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    cfg_we_i <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx != REG_VOID) regs[idx] = data;
  endtask

  task automatic load_settings(input reg_set_t s);
    drain();
    for (int i = 0; i < NREGS; i++) reg_write(CFG_IDX_W'(i), s[i]);
  endtask

  task automatic send_word(input logic [CH_W-1:0] ch, input logic signed [DELTA_W-1:0] delta,
                           input bit typed = 1'b0, input drive_word_t typed_word = '0);
    drive_word_t w;
    cfg_we_i <= 1'b0;
    while (!steady && $urandom_range(0, 99) < 37) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.channel <= ch;
    in_if.encoder_delta <= delta;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    w = pid_update(ch, delta);
    pending_drives.push_back(typed ? typed_word : w);
  endtask

  task automatic run_phase(input reg_set_t s, input int n_words, input bit calm);
    load_settings(s);
    steady = calm;
    repeat (n_words) send_word(CH_W'($urandom_range(0, 3)), random_delta());
    steady = 1'b0;
  endtask

  always @(posedge clk_i) begin : drive_sink
    drive_word_t got;
    drive_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.ch = out_if.out_channel;
      got.drive = out_if.drive_value;
      got.speed = out_if.measured_speed;
      if (pending_drives.size() == 0) begin
        note_error($sformatf("word for channel %0d with none pending", got.ch));
      end else begin
        want = pending_drives.pop_front();
        if (got.ch !== want.ch)
          note_error($sformatf("channel: expected %0d, got %0d", want.ch, got.ch));
        if (got.drive !== want.drive)
          note_error($sformatf("ch %0d drive: expected %0d, got %0d",
                               want.ch, want.drive, got.drive));
        if (got.speed !== want.speed)
          note_error($sformatf("ch %0d speed: expected %0d, got %0d",
                               want.ch, want.speed, got.speed));
      end
    end
    out_if.ready <= steady || ($urandom_range(0, 99) >= 37);
  end

  initial begin
    reg_set_t s;
    drive_word_t tw;
    bit prev_reg;
    int unsigned n0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.channel = '0;
    in_if.encoder_delta = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < NREGS; i++) regs[i] = '0;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      last_err[c] = '0;
      err_sum[c] = '0;
      drive_acc[c] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    prev_reg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!prev_reg) drain();
        reg_write(plan[i].idx, plan[i].data);
      end else begin
        tw.ch = plan[i].ch;
        tw.drive = plan[i].drive;
        tw.speed = plan[i].speed;
        send_word(plan[i].ch, plan[i].delta, plan[i].typed, tw);
      end
      prev_reg = plan[i].is_reg;
    end

    run_phase(random_settings(), 60, 1'b0);
    run_phase(random_settings(), 60, 1'b1);

    // zero the channel 0 integral, then pull its drive down to the lower clamp
    s = regs;
    s[REG_TARGET0] = -err_sum[0];
    load_settings(s);
    send_word(2'd0, 12'sd0);
    s = random_settings();
    s[REG_TARGET0] = 16'h8000;
    s[REG_GAIN_P] = 16'hFFFF;
    s[REG_GAIN_I] = 16'hFFFF;
    s[REG_GAIN_D] = 16'hFFFF;
    load_settings(s);
    n0 = 0;
    while (n0 < 200) begin
      if ($urandom_range(0, 5) == 0) begin
        send_word(CH_W'($urandom_range(1, 3)), random_delta());
      end else begin
        send_word(2'd0, 12'sd0);
        n0++;
      end
    end

    run_phase(random_settings(), 60, 1'b0);
    s = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000};
    run_phase(s, 40, 1'b0);

    drain();
    if (bad_fields == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pidspd_pkg.sv
rtl/core/pidspd_in_if.sv
rtl/core/pidspd_out_if.sv
rtl/core/pidspd_ram.sv
rtl/core/pidspd_err.sv
rtl/core/pidspd_drv.sv
rtl/core/four_channel_incremental_pid_speed_unit.sv
tb/sv/tb_four_channel_incremental_pid_speed_unit.sv
